// File: rtl/pmst_pkg.sv
// Shared types and constants for the Prim spanning tree block.
// Holds the command and result word formats and the opcode and status codes.
// No dependencies.
package pmst_pkg;

	// Fixed field widths of the command and result words.
	localparam int VERT_W   = 4;
	localparam int WFIELD_W = 16;
	localparam int VCOUNT_W = 5;

	// Vertex count after reset.
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

	// Command opcodes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RUN   = 1'b1;

	// Result status codes.
	localparam logic ST_EDGE         = 1'b0;
	localparam logic ST_DISCONNECTED = 1'b1;

	typedef struct packed {
		logic                opcode;
		logic [VERT_W-1:0]   row;
		logic [VERT_W-1:0]   col;
		logic [WFIELD_W-1:0] weight;
	} cmd_word_t;

	typedef struct packed {
		logic [VERT_W-1:0]   edge_from;
		logic [VERT_W-1:0]   edge_to;
		logic [WFIELD_W-1:0] edge_weight;
		logic                status;
		logic                last;
	} res_word_t;

	// Result word handed from the sequencer to the output register.
	typedef struct packed {
		logic      valid;
		res_word_t word;
	} emit_t;

endpackage

// File: rtl/pmst_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the cost matrix and the per-vertex tree table. No dependencies.
module pmst_ram #(
	parameter int ADDR_W = 8,
	parameter int WIDTH  = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/pmst_ctrl.sv
// Sequencer for the Prim spanning tree block: takes command words, scans the
// cost matrix for the first edge and sweeps the tree table once per added vertex.
// Depends on pmst_pkg; drives the two pmst_ram instances in the top level.
module pmst_ctrl #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16,
	parameter int VIDX_W       = 4,
	parameter int TREE_W       = 21
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  pmst_pkg::cmd_word_t             cmd,
	input  logic [pmst_pkg::VCOUNT_W-1:0]   vertex_count,
	input  logic                            emit_ok,
	output pmst_pkg::emit_t                 emit,
	output logic                            cost_we,
	output logic [2*VIDX_W-1:0]             cost_waddr,
	output logic [WEIGHT_BITS-1:0]          cost_wdata,
	output logic [2*VIDX_W-1:0]             cost_raddr,
	input  logic [WEIGHT_BITS-1:0]          cost_rdata,
	output logic                            tree_we,
	output logic [VIDX_W-1:0]               tree_waddr,
	output logic [TREE_W-1:0]               tree_wdata,
	output logic [VIDX_W-1:0]               tree_raddr,
	input  logic [TREE_W-1:0]               tree_rdata
);

	import pmst_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (VCOUNT_W > CNT_W) ? VCOUNT_W : CNT_W;
	localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

	typedef struct packed {
		logic                   in_tree;
		logic [VIDX_W-1:0]      nearest;
		logic [WEIGHT_BITS-1:0] near_cost;
	} tree_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SCAN_WAIT, S_FIRST, S_LOAD, S_SWEEP, S_SWEEP_WAIT, S_PICK
	} state_t;

	state_t state_q, state_d;

	// Loop counters and run bookkeeping.
	logic [VIDX_W-1:0]      i_q, j_q, k_q, u_q, last_q;
	logic [CNT_W-1:0]       rem_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic [VIDX_W-1:0]      best_a_q, best_b_q;

	// Read stage: address that was issued in the previous cycle.
	logic              scan_s1, load_s1, sweep_s1;
	logic [VIDX_W-1:0] i_s1, j_s1, k_s1;

	logic              run_go, best_clr, take_scan, take_sweep;
	logic              j_at_end, i_at_end, no_edge;
	logic [CMP_W-1:0]  vc_ext, n_sat;
	tree_t             tr_rd, tr_wr;

	assign tr_rd      = tree_t'(tree_rdata);
	assign tree_wdata = TREE_W'(tr_wr);

	assign cmd_ready = (state_q == S_IDLE);
	assign run_go    = cmd_valid && cmd_ready && (cmd.opcode == OP_RUN);
	assign j_at_end  = (j_q == last_q);
	assign i_at_end  = (i_q == last_q - 1'b1);
	assign no_edge   = (best_q == NO_EDGE);

	// Vertex count saturated to the supported range.
	always_comb begin
		vc_ext = CMP_W'(vertex_count);
		if (vc_ext < CMP_W'(2)) begin
			n_sat = CMP_W'(2);
		end else if (vc_ext > CMP_W'(MAX_VERTICES)) begin
			n_sat = CMP_W'(MAX_VERTICES);
		end else begin
			n_sat = vc_ext;
		end
	end

	// Matrix writes from command words; entries beyond the matrix are dropped.
	always_comb begin
		cost_we    = cmd_valid && cmd_ready && (cmd.opcode == OP_WRITE) &&
		             (32'(cmd.row) < MAX_VERTICES) && (32'(cmd.col) < MAX_VERTICES);
		cost_waddr = {VIDX_W'(cmd.row), VIDX_W'(cmd.col)};
		cost_wdata = WEIGHT_BITS'(cmd.weight);
	end

	// Read addresses for the current issue cycle.
	always_comb begin
		if (state_q == S_SCAN) begin
			cost_raddr = {i_q, j_q};
		end else begin
			cost_raddr = {j_q, k_q};
		end
		tree_raddr = j_q;
	end

	// Update of one tree table entry from the returned matrix word.
	always_comb begin
		tr_wr = tr_rd;
		if (load_s1) begin
			tr_wr.in_tree   = (j_s1 == u_q) || (j_s1 == k_s1);
			tr_wr.nearest   = k_s1;
			tr_wr.near_cost = cost_rdata;
		end else begin
			tr_wr.in_tree = tr_rd.in_tree || (j_s1 == k_s1);
			if (!tr_wr.in_tree && (cost_rdata < tr_rd.near_cost)) begin
				tr_wr.nearest   = k_s1;
				tr_wr.near_cost = cost_rdata;
			end
		end
		tree_we    = load_s1 || sweep_s1;
		tree_waddr = j_s1;
		take_scan  = scan_s1 && (cost_rdata < best_q);
		take_sweep = sweep_s1 && !tr_wr.in_tree && (tr_wr.near_cost < best_q);
	end

	// Next state and result words.
	always_comb begin
		state_d    = state_q;
		best_clr   = 1'b0;
		emit.valid = 1'b0;
		emit.word  = '{edge_from: VERT_W'(best_a_q), edge_to: VERT_W'(best_b_q),
		               edge_weight: WFIELD_W'(best_q), status: ST_EDGE, last: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (run_go) begin
					state_d  = S_SCAN;
					best_clr = 1'b1;
				end
			end
			S_SCAN: begin
				if (j_at_end && i_at_end) begin
					state_d = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: begin
				state_d = S_FIRST;
			end
			S_FIRST: begin
				emit.word.last = (rem_q == '0);
				if (emit_ok) begin
					emit.valid = 1'b1;
					state_d    = (no_edge || rem_q == '0) ? S_IDLE : S_LOAD;
				end
			end
			S_LOAD: begin
				if (j_at_end) begin
					state_d  = S_SWEEP;
					best_clr = 1'b1;
				end
			end
			S_SWEEP: begin
				if (j_at_end) begin
					state_d = S_SWEEP_WAIT;
				end
			end
			S_SWEEP_WAIT: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				emit.word.last = (rem_q == CNT_W'(1));
				if (emit_ok) begin
					emit.valid = 1'b1;
					if (no_edge || rem_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						state_d  = S_SWEEP;
						best_clr = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// No finite edge left: a disconnected word closes the run.
		if (no_edge) begin
			emit.word = '{edge_from: '0, edge_to: '0, edge_weight: '0,
			              status: ST_DISCONNECTED, last: 1'b1};
		end
	end

	// State and read stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			scan_s1  <= 1'b0;
			load_s1  <= 1'b0;
			sweep_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			scan_s1  <= (state_q == S_SCAN);
			load_s1  <= (state_q == S_LOAD);
			sweep_s1 <= (state_q == S_SWEEP);
		end
	end

	// Counters, pivots and the running minimum.
	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		j_s1 <= j_q;
		k_s1 <= k_q;

		if (best_clr) begin
			best_q <= NO_EDGE;
		end else if (take_scan) begin
			best_q   <= cost_rdata;
			best_a_q <= i_s1;
			best_b_q <= j_s1;
		end else if (take_sweep) begin
			best_q   <= tr_wr.near_cost;
			best_a_q <= j_s1;
			best_b_q <= tr_wr.nearest;
		end

		case (state_q)
			S_IDLE: begin
				if (run_go) begin
					last_q <= VIDX_W'(n_sat - CMP_W'(1));
					rem_q  <= CNT_W'(n_sat - CMP_W'(2));
					i_q    <= '0;
					j_q    <= VIDX_W'(1);
				end
			end
			S_SCAN: begin
				if (j_at_end) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + VIDX_W'(2);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_FIRST: begin
				if (emit_ok) begin
					u_q <= best_a_q;
					k_q <= best_b_q;
					j_q <= '0;
				end
			end
			S_LOAD: begin
				if (j_at_end) begin
					j_q <= '0;
					k_q <= u_q;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_SWEEP: begin
				j_q <= j_q + 1'b1;
			end
			S_PICK: begin
				if (emit_ok) begin
					k_q   <= best_a_q;
					rem_q <= rem_q - 1'b1;
					j_q   <= '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/prim_min_spanning_tree_core.sv
// Write words are accepted back to back while the sequencer is idle. A run word
// keeps the block busy while the sequencer scans the cost matrix through its
// single read port and sweeps the tree table; a result stall holds the run.
// Results leave through a one-word output register. Reset is asynchronous and
// active low: it idles the sequencer and sets the vertex count to 16; the cost
// matrix is not cleared.
module prim_min_spanning_tree_core #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  pmst_pkg::cmd_word_t           cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output pmst_pkg::res_word_t           res,
	input  logic                          cfg_we,
	input  logic [pmst_pkg::VCOUNT_W-1:0] cfg_wdata
);

	import pmst_pkg::*;

	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int TREE_W = 1 + VIDX_W + WEIGHT_BITS;

	logic [VCOUNT_W-1:0]    vcount_q;
	logic                   res_valid_q;
	res_word_t              res_q;
	emit_t                  emit;
	logic                   emit_ok;

	logic                   cost_we;
	logic [2*VIDX_W-1:0]    cost_waddr, cost_raddr;
	logic [WEIGHT_BITS-1:0] cost_wdata, cost_rdata;
	logic                   tree_we;
	logic [VIDX_W-1:0]      tree_waddr, tree_raddr;
	logic [TREE_W-1:0]      tree_wdata, tree_rdata;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// Output register: a new word may load while the held one is taken.
	assign emit_ok   = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit.valid) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			res_q <= emit.word;
		end
	end

	// Cost matrix, indexed by row and column.
	pmst_ram #(
		.ADDR_W(2 * VIDX_W),
		.WIDTH (WEIGHT_BITS)
	) u_cost_ram (
		.clk  (clk),
		.we   (cost_we),
		.waddr(cost_waddr),
		.wdata(cost_wdata),
		.raddr(cost_raddr),
		.rdata(cost_rdata)
	);

	// Tree table: membership, nearest tree vertex and its edge cost.
	pmst_ram #(
		.ADDR_W(VIDX_W),
		.WIDTH (TREE_W)
	) u_tree_ram (
		.clk  (clk),
		.we   (tree_we),
		.waddr(tree_waddr),
		.wdata(tree_wdata),
		.raddr(tree_raddr),
		.rdata(tree_rdata)
	);

	pmst_ctrl #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.VIDX_W      (VIDX_W),
		.TREE_W      (TREE_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.vertex_count(vcount_q),
		.emit_ok     (emit_ok),
		.emit        (emit),
		.cost_we     (cost_we),
		.cost_waddr  (cost_waddr),
		.cost_wdata  (cost_wdata),
		.cost_raddr  (cost_raddr),
		.cost_rdata  (cost_rdata),
		.tree_we     (tree_we),
		.tree_waddr  (tree_waddr),
		.tree_wdata  (tree_wdata),
		.tree_raddr  (tree_raddr),
		.tree_rdata  (tree_rdata)
	);

`ifndef SYNTH
	// A word is only handed over when the output register can take it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (!res_valid_q || res_ready))
		else $error("result word overwrote a pending word");

	// A disconnected status always closes the run.
	a_disc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_DISCONNECTED) |-> res.last)
		else $error("disconnected word without last");

	// While a run still has words to deliver, no command is taken.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && !emit.word.last) |=> !cmd_ready)
		else $error("command taken in the middle of a run");

	// Matrix writes happen only while no run is in progress.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cost_we |-> (cmd_ready && cmd_valid))
		else $error("matrix written outside a write command");
`endif

endmodule
